// ----- rtl/bit_packer_fixed_and_vbr_unit_macros.svh -----
// Assertion macros shared by the bit packer RTL.
// Depends on a clock named clk and an active-high reset named rst in the including scope.
`ifndef BIT_PACKER_FIXED_AND_VBR_UNIT_MACROS_SVH
`define BIT_PACKER_FIXED_AND_VBR_UNIT_MACROS_SVH

// Same-cycle implication, muted while reset is high.
`define BPK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, muted while reset is high.
`define BPK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bpk_pkg.sv -----
// Types, codes and microcode ROM for the bit packer sequencer.
// No dependencies; used by bit_packer_fixed_and_vbr_unit.
package bpk_pkg;

  localparam int UPC_W = 5;

  typedef enum logic [1:0] {
    OP_FIXED = 2'd0,
    OP_VBR   = 2'd1,
    OP_ALIGN = 2'd2,
    OP_RAW   = 2'd3
  } op_t;

  // What a step hands to the result path.
  typedef enum logic [2:0] {
    EMIT_NONE = 3'd0,
    EMIT_LO   = 3'd1,
    EMIT_HI   = 3'd2,
    EMIT_RAW  = 3'd3,
    EMIT_CNT  = 3'd4,
    EMIT_ERR  = 3'd5
  } emit_t;

  // Jump conditions.
  typedef enum logic [2:0] {
    COND_NEVER     = 3'd0,
    COND_ALWAYS    = 3'd1,
    COND_NO_SPILL  = 3'd2,
    COND_MORE      = 3'd3,
    COND_FILL_ZERO = 3'd4,
    COND_FILL_LE32 = 3'd5,
    COND_IS_RAW    = 3'd6,
    COND_TOO_WIDE  = 3'd7
  } cond_t;

  typedef struct packed {
    emit_t            emit;
    logic             push;
    logic             clr;
    logic             fin;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } ucode_t;

  // Program entry points, jump targets and the common finishing step.
  localparam logic [UPC_W-1:0] ENTRY_ALIGN = 5'd0;
  localparam logic [UPC_W-1:0] STEP_ALN_CLR = 5'd3;
  localparam logic [UPC_W-1:0] STEP_RAW_OUT = 5'd5;
  localparam logic [UPC_W-1:0] ENTRY_FIXED = 5'd6;
  localparam logic [UPC_W-1:0] STEP_FIX_ERR = 5'd11;
  localparam logic [UPC_W-1:0] ENTRY_VBR = 5'd12;
  localparam logic [UPC_W-1:0] STEP_VBR_TEST = 5'd16;
  localparam logic [UPC_W-1:0] STEP_FIN = 5'd17;

  function automatic ucode_t mk(input emit_t e, input logic p, input logic c, input logic f,
                                input cond_t cd, input logic [UPC_W-1:0] t);
    ucode_t w;
    w.emit   = e;
    w.push   = p;
    w.clr    = c;
    w.fin    = f;
    w.cond   = cd;
    w.target = t;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] a);
    ucode_t w;
    case (a)
      // align and aligned raw word: flush, clear, then count or raw word
      5'd0:  w = mk(EMIT_NONE, 1'b0, 1'b0, 1'b0, COND_FILL_ZERO, STEP_ALN_CLR);
      5'd1:  w = mk(EMIT_LO,   1'b0, 1'b0, 1'b0, COND_FILL_LE32, STEP_ALN_CLR);
      5'd2:  w = mk(EMIT_HI,   1'b0, 1'b0, 1'b0, COND_NEVER,     STEP_FIN);
      5'd3:  w = mk(EMIT_NONE, 1'b0, 1'b1, 1'b0, COND_IS_RAW,    STEP_RAW_OUT);
      5'd4:  w = mk(EMIT_CNT,  1'b0, 1'b0, 1'b0, COND_ALWAYS,    STEP_FIN);
      5'd5:  w = mk(EMIT_RAW,  1'b0, 1'b0, 1'b0, COND_ALWAYS,    STEP_FIN);
      // fixed append
      5'd6:  w = mk(EMIT_NONE, 1'b0, 1'b0, 1'b0, COND_TOO_WIDE,  STEP_FIX_ERR);
      5'd7:  w = mk(EMIT_NONE, 1'b1, 1'b0, 1'b0, COND_NEVER,     STEP_FIN);
      5'd8:  w = mk(EMIT_NONE, 1'b0, 1'b0, 1'b0, COND_NO_SPILL,  STEP_FIN);
      5'd9:  w = mk(EMIT_LO,   1'b0, 1'b0, 1'b0, COND_NEVER,     STEP_FIN);
      5'd10: w = mk(EMIT_HI,   1'b0, 1'b0, 1'b0, COND_ALWAYS,    STEP_FIN);
      5'd11: w = mk(EMIT_ERR,  1'b0, 1'b0, 1'b0, COND_ALWAYS,    STEP_FIN);
      // vbr append: one chunk per pass
      5'd12: w = mk(EMIT_NONE, 1'b1, 1'b0, 1'b0, COND_NEVER,     STEP_FIN);
      5'd13: w = mk(EMIT_NONE, 1'b0, 1'b0, 1'b0, COND_NO_SPILL,  STEP_VBR_TEST);
      5'd14: w = mk(EMIT_LO,   1'b0, 1'b0, 1'b0, COND_NEVER,     STEP_FIN);
      5'd15: w = mk(EMIT_HI,   1'b0, 1'b0, 1'b0, COND_NEVER,     STEP_FIN);
      5'd16: w = mk(EMIT_NONE, 1'b0, 1'b0, 1'b0, COND_MORE,      ENTRY_VBR);
      5'd17: w = mk(EMIT_NONE, 1'b0, 1'b0, 1'b1, COND_NEVER,     STEP_FIN);
      default: w = mk(EMIT_NONE, 1'b0, 1'b0, 1'b1, COND_NEVER,   STEP_FIN);
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/bit_packer_fixed_and_vbr_unit.sv -----
// Bit packer top level: microcoded sequencer over a 64-bit packing buffer.
// Depends on bpk_pkg and bit_packer_fixed_and_vbr_unit_macros.svh.
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+----------------------------------------------
//  s_*     | in  | s_tvalid / s_tready        | tuser: operation; tdata: data_value, field_width
//  m_*     | out | m_tvalid / m_tready        | tdata: out_word, word_position;
//          |     |                            | tuser: word_present, too_wide_error; tlast
//
// Sequencing: one item at a time. After the accept, the microprogram runs one step a
//   cycle unless stalled: fixed append 4 steps (6 with a spilled word pair, 3 when
//   rejected), vbr 1 step plus 3 per chunk plus 2 per spilled pair, align or raw word
//   4 to 6 steps. The ROM program and the single buffer shifter set these step counts.
// Reset: rst (synchronous) empties the buffer, zeroes the word counter, drops held words.
// Stalls: a step that hands a word on waits while the output register is full and not
//   taken; s_tready stays low until the finishing step has delivered the last word.
`include "bit_packer_fixed_and_vbr_unit_macros.svh"

module bit_packer_fixed_and_vbr_unit #(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // [63:0] data_value, [69:64] field_width, [71:70] zero
  input  logic [1:0]  s_tuser,   // [1:0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [31:0] out_word, [63:32] word_position
  output logic [1:0]  m_tuser,   // [0] word_present, [1] too_wide_error
  output logic        m_tlast
);

  // ---------------------------------------------------------------- sequencer
  logic                       busy;
  logic [bpk_pkg::UPC_W-1:0]  upc;
  bpk_pkg::ucode_t            uc;
  logic                       out_free;
  logic                       stall;
  logic                       advance;
  logic                       take;
  logic                       jump;

  // ---------------------------------------------------------------- datapath
  bpk_pkg::op_t     op;
  logic [63:0]      val;
  logic [5:0]       fw;
  logic [63:0]      buffer;
  logic [5:0]       fill;
  logic [31:0]      carry;
  logic             spill;
  logic             more;
  logic [COUNT_BITS-1:0] cnt;

  logic [5:0]       wfix;
  logic [5:0]       wvbr;
  logic [4:0]       pay;
  logic [63:0]      vsh;
  logic             more_now;
  logic [31:0]      lowmask;
  logic [31:0]      chunk;
  logic [5:0]       wpush;
  logic [63:0]      merged;
  logic [6:0]       sum;
  logic [31:0]      carry_next;
  logic             too_wide;

  // held result (one behind) and output register
  logic             held_valid;
  logic [31:0]      held_word;
  logic             held_present;
  logic [31:0]      held_pos;
  logic             held_err;
  logic [31:0]      new_word;
  logic             new_present;
  logic             new_err;
  logic [31:0]      pos_now;
  logic             load_out;
  logic [31:0]      out_word;
  logic [31:0]      out_pos;
  logic             out_present;
  logic             out_err;
  logic             out_last;

  assign uc       = bpk_pkg::ucode_rom(upc);
  assign out_free = !m_tvalid || m_tready;
  assign take     = s_tvalid && s_tready;
  assign s_tready = !rst && !busy;

  // Hold a step while its result cannot move on.
  assign stall = busy && ((uc.emit != bpk_pkg::EMIT_NONE && held_valid && !out_free) ||
                          (uc.fin && !out_free));
  assign advance = busy && !stall;

  always_comb begin
    case (uc.cond)
      bpk_pkg::COND_NEVER:     jump = 1'b0;
      bpk_pkg::COND_ALWAYS:    jump = 1'b1;
      bpk_pkg::COND_NO_SPILL:  jump = !spill;
      bpk_pkg::COND_MORE:      jump = more;
      bpk_pkg::COND_FILL_ZERO: jump = (fill == 6'd0);
      bpk_pkg::COND_FILL_LE32: jump = (fill <= 6'd32);
      bpk_pkg::COND_IS_RAW:    jump = (op == bpk_pkg::OP_RAW);
      bpk_pkg::COND_TOO_WIDE:  jump = too_wide;
      default:                 jump = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      upc  <= bpk_pkg::STEP_FIN;
    end else if (take) begin
      busy <= 1'b1;
      case (bpk_pkg::op_t'(s_tuser))
        bpk_pkg::OP_FIXED: upc <= bpk_pkg::ENTRY_FIXED;
        bpk_pkg::OP_VBR:   upc <= bpk_pkg::ENTRY_VBR;
        default:           upc <= bpk_pkg::ENTRY_ALIGN;
      endcase
    end else if (advance) begin
      if (uc.fin) begin
        busy <= 1'b0;
      end else if (jump) begin
        upc <= uc.target;
      end else begin
        upc <= upc + bpk_pkg::UPC_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------- chunk and merge
  assign wfix     = (fw > 6'd32) ? 6'd32 : fw;
  assign wvbr     = (wfix < 6'd2) ? 6'd2 : wfix;
  assign pay      = 5'(wvbr - 6'd1);
  assign vsh      = val >> pay;
  assign more_now = (vsh != 64'd0);
  assign lowmask  = (32'd1 << pay) - 32'd1;
  assign too_wide = ((val >> wfix) != 64'd0);

  always_comb begin
    if (op == bpk_pkg::OP_VBR) begin
      chunk = (val[31:0] & lowmask) | (32'(more_now) << pay);
      wpush = wvbr;
    end else begin
      chunk = val[31:0];
      wpush = wfix;
    end
  end

  assign merged     = buffer | ({32'd0, chunk} << fill);
  assign sum        = {1'b0, fill} + {1'b0, wpush};
  // Bits that overflow a full buffer start the next one.
  assign carry_next = 32'({32'd0, chunk} >> (7'd64 - {1'b0, fill}));

  always_ff @(posedge clk) begin
    if (take) begin
      op  <= bpk_pkg::op_t'(s_tuser);
      val <= s_tdata[63:0];
      fw  <= s_tdata[69:64];
    end else if (advance && uc.push && op == bpk_pkg::OP_VBR) begin
      val  <= vsh;
      more <= more_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer <= 64'd0;
      fill   <= 6'd0;
      spill  <= 1'b0;
    end else if (advance) begin
      if (uc.push) begin
        buffer <= merged;
        fill   <= sum[5:0];
        spill  <= sum[6];
        carry  <= carry_next;
      end else if (uc.emit == bpk_pkg::EMIT_HI) begin
        buffer <= {32'd0, carry};
        spill  <= 1'b0;
      end else if (uc.clr) begin
        buffer <= 64'd0;
        fill   <= 6'd0;
      end
    end
  end

  // ---------------------------------------------------------------- results
  assign pos_now = 32'(cnt);

  always_comb begin
    new_word    = 32'd0;
    new_present = 1'b0;
    new_err     = 1'b0;
    case (uc.emit)
      bpk_pkg::EMIT_LO: begin
        new_word    = buffer[31:0];
        new_present = 1'b1;
      end
      bpk_pkg::EMIT_HI: begin
        new_word    = buffer[63:32];
        new_present = 1'b1;
      end
      bpk_pkg::EMIT_RAW: begin
        new_word    = val[31:0];
        new_present = 1'b1;
      end
      bpk_pkg::EMIT_ERR: new_err = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (advance && new_present) begin
      cnt <= cnt + COUNT_BITS'(1);
    end
  end

  // Keep the newest result back one step so the final one can carry tlast.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (advance && uc.fin) begin
      held_valid <= 1'b0;
    end else if (advance && uc.emit != bpk_pkg::EMIT_NONE) begin
      held_valid   <= 1'b1;
      held_word    <= new_word;
      held_present <= new_present;
      held_pos     <= pos_now;
      held_err     <= new_err;
    end
  end

  assign load_out = advance && (uc.fin || (uc.emit != bpk_pkg::EMIT_NONE && held_valid));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_last <= uc.fin;
      if (held_valid) begin
        out_word    <= held_word;
        out_present <= held_present;
        out_pos     <= held_pos;
        out_err     <= held_err;
      end else begin
        // nothing emitted by this item: report the word count alone
        out_word    <= 32'd0;
        out_present <= 1'b0;
        out_pos     <= pos_now;
        out_err     <= 1'b0;
      end
    end
  end

  assign m_tdata = {out_pos, out_word};
  assign m_tuser = {out_err, out_present};
  assign m_tlast = out_last;

  // ---------------------------------------------------------------- checks
  `BPK_ASSERT_NOW(a_idle_nothing_held, !busy, !held_valid, "held result left after item end")
  `BPK_ASSERT_NOW(a_fin_no_spill, busy && uc.fin, !spill, "spilled word pair not delivered")
  `BPK_ASSERT_NOW(a_err_alone, m_tvalid && m_tuser[1], m_tlast && !m_tuser[0], "error result mixed with a word")
  `BPK_ASSERT_NEXT(a_fin_ends_item, advance && uc.fin, m_tvalid && m_tlast && !busy, "finish step did not close the item")

endmodule

// ----- bench/bit_packer_fixed_and_vbr_unit_tb.sv -----
// Self-checking bench for bit_packer_fixed_and_vbr_unit: drives fixed, vbr, align and raw
// items on the slave stream and checks every word on the master stream against a packer
// model held here. Depends on bpk_pkg and the top-level RTL only.
`timescale 1ns / 100ps

module bit_packer_fixed_and_vbr_unit_tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 50;

  // One expected master-side word.
  typedef struct {
    logic [31:0] out_word;
    logic        present;
    logic [31:0] position;
    logic        too_wide;
    logic        last;
  } packed_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;   // [63:0] data_value, [69:64] field_width, [71:70] zero
  logic [1:0]  s_tuser = '0;   // [1:0] operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // [31:0] out_word, [63:32] word_position
  logic [1:0]  m_tuser;        // [0] word_present, [1] too_wide_error
  logic        m_tlast;

  // Model state of the packer.
  logic [63:0]  pack_buffer = '0;
  int unsigned  pack_fill = 0;
  logic [31:0]  words_sent = '0;

  packed_word_t item_words[$];      // words of the item being predicted
  packed_word_t expected_words[$];  // words still owed by the block

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          idle_on = 1'b1;

  bit_packer_fixed_and_vbr_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Packer model
  // ---------------------------------------------------------------------------

  // Add one word to the current item; a present word takes the next index.
  function automatic void add_word(logic [31:0] data, logic present, logic too_wide);
    packed_word_t w;
    w.out_word = present ? data : 32'd0;
    w.present  = present;
    w.position = words_sent;
    w.too_wide = too_wide;
    w.last     = 1'b0;
    item_words.insert(item_words.size(), w);
    if (present)
      words_sent = words_sent + 32'd1;
  endfunction

  // Append bits LSB-first; a full buffer leaves as a word pair, low half first.
  function automatic void append_bits(logic [63:0] bits, int unsigned width);
    logic [63:0] merged;
    int unsigned fill;
    merged = pack_buffer | (bits << pack_fill);
    fill = pack_fill + width;
    if (fill >= 64) begin
      add_word(merged[31:0], 1'b1, 1'b0);
      add_word(merged[63:32], 1'b1, 1'b0);
      fill = fill - 64;
      merged = bits >> (width - fill);
    end
    pack_buffer = merged;
    pack_fill = fill;
  endfunction

  // Flush a partial buffer as one word, or two when more than 32 bits wait.
  function automatic void flush_buffer();
    if (pack_fill != 0) begin
      add_word(pack_buffer[31:0], 1'b1, 1'b0);
      if (pack_fill > 32)
        add_word(pack_buffer[63:32], 1'b1, 1'b0);
      pack_fill = 0;
      pack_buffer = '0;
    end
  endfunction

  // Work out the words one item causes and queue them behind earlier ones.
  function automatic void predict_packer_item(bpk_pkg::op_t op, logic [63:0] value,
                                              logic [5:0] width_field);
    int unsigned width;
    int unsigned payload;
    logic [63:0] rest;
    logic [63:0] more_flag;
    item_words.delete();
    width = 32'(width_field);
    if (width > 32)
      width = 32;
    case (op)
      bpk_pkg::OP_FIXED: begin
        // too wide covers a nonzero value of width zero as well
        if ((value >> width) != 64'd0)
          add_word(32'd0, 1'b0, 1'b1);
        else if (width != 0)
          append_bits(value, width);
      end
      bpk_pkg::OP_VBR: begin
        if (width < 2)
          width = 2;
        payload = width - 1;
        more_flag = 64'd1 << payload;
        rest = value;
        while ((rest >> payload) != 64'd0) begin
          append_bits((rest & (more_flag - 64'd1)) | more_flag, width);
          rest = rest >> payload;
        end
        append_bits(rest, width);
      end
      bpk_pkg::OP_ALIGN: begin
        flush_buffer();
        add_word(32'd0, 1'b0, 1'b0);
      end
      default: begin
        // raw word: upper half of the value is dropped
        flush_buffer();
        add_word(value[31:0], 1'b1, 1'b0);
      end
    endcase
    if (item_words.size() == 0)
      add_word(32'd0, 1'b0, 1'b0);
    item_words[item_words.size() - 1].last = 1'b1;
    foreach (item_words[i])
      expected_words.insert(expected_words.size(), item_words[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("[%0t] word mismatch on %s: got 0x%0h, want 0x%0h", $realtime, field, got, want);
  endtask

  // Compare each accepted master word with the oldest expected word.
  always @(posedge clk) begin
    packed_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", m_tdata, 64'd0);
      end else begin
        want = expected_words.pop_front();
        if (m_tdata[31:0] !== want.out_word)
          report_mismatch("out_word", 64'(m_tdata[31:0]), 64'(want.out_word));
        if (m_tuser[0] !== want.present)
          report_mismatch("word_present", 64'(m_tuser[0]), 64'(want.present));
        if (m_tdata[63:32] !== want.position)
          report_mismatch("word_position", 64'(m_tdata[63:32]), 64'(want.position));
        if (m_tuser[1] !== want.too_wide)
          report_mismatch("too_wide_error", 64'(m_tuser[1]), 64'(want.too_wide));
        if (m_tlast !== want.last)
          report_mismatch("last_result", 64'(m_tlast), 64'(want.last));
      end
    end
  end

  // Stall the master side at random while idling is on.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 10);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               expected_words.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random value of random magnitude, so vbr chunk counts spread out.
  function automatic logic [63:0] rand_magnitude();
    return rand64() >> $urandom_range(0, 64);
  endfunction

  function automatic logic [63:0] width_mask(int unsigned width);
    return (64'd1 << width) - 64'd1;
  endfunction

  // Send one item; valid stays high after the handshake so back-to-back items
  // never lower and raise it in the same step.
  task automatic send_item(bpk_pkg::op_t op, logic [63:0] value, logic [5:0] width);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    predict_packer_item(op, value, width);
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, width, value};
    s_tuser  <= op;
    do @(posedge clk); while (!(s_tvalid && s_tready));
  endtask

  // Drop valid and hold until every expected word has come back.
  task automatic drain_words();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_fixed_edges();
    send_item(bpk_pkg::OP_FIXED, 64'd0, 6'd1);
    send_item(bpk_pkg::OP_FIXED, 64'd1, 6'd1);
    send_item(bpk_pkg::OP_FIXED, 64'hFFFF_FFFF, 6'd32);
    send_item(bpk_pkg::OP_FIXED, 64'h1_0000_0000, 6'd32);          // one bit past the width
    send_item(bpk_pkg::OP_FIXED, 64'd0, 6'd0);                     // zero width, zero value
    send_item(bpk_pkg::OP_FIXED, 64'd1, 6'd0);                     // zero width, nonzero value
    send_item(bpk_pkg::OP_FIXED, 64'hFFFF_FFFF, 6'd63);            // width clamps to 32
    send_item(bpk_pkg::OP_FIXED, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63);  // too wide after the clamp
    send_item(bpk_pkg::OP_FIXED, 64'h1234_5678, 6'd31);            // leaves 33 bits buffered
  endtask

  task automatic test_vbr_edges();
    send_item(bpk_pkg::OP_VBR, 64'd5, 6'd0);                       // width raised to 2
    send_item(bpk_pkg::OP_VBR, 64'd3, 6'd1);
    send_item(bpk_pkg::OP_VBR, 64'd0, 6'd2);
    send_item(bpk_pkg::OP_VBR, 64'd127, 6'd8);                     // fills one chunk exactly
    send_item(bpk_pkg::OP_VBR, 64'd128, 6'd8);                     // needs a second chunk
    send_item(bpk_pkg::OP_VBR, 64'hFFFF_FFFF_FFFF_FFFF, 6'd32);
    send_item(bpk_pkg::OP_VBR, 64'hFFFF_FFFF_FFFF_FFFF, 6'd2);     // 64 chunks, two word pairs
    send_item(bpk_pkg::OP_VBR, 64'hDEAD_BEEF_0000_0001, 6'd40);    // width clamps to 32
  endtask

  task automatic test_align_and_raw();
    send_item(bpk_pkg::OP_ALIGN, 64'd0, 6'd0);
    send_item(bpk_pkg::OP_ALIGN, 64'd0, 6'd0);                     // empty buffer: count only
    send_item(bpk_pkg::OP_FIXED, 64'hA5, 6'd8);
    send_item(bpk_pkg::OP_ALIGN, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63);  // one word flushed
    send_item(bpk_pkg::OP_FIXED, 64'hCAFE_F00D, 6'd32);
    send_item(bpk_pkg::OP_FIXED, 64'h3C, 6'd8);
    send_item(bpk_pkg::OP_ALIGN, 64'd0, 6'd1);                     // two words flushed
    send_item(bpk_pkg::OP_RAW, 64'hFFFF_FFFF_0BAD_CAFE, 6'd0);     // upper half dropped
    send_item(bpk_pkg::OP_FIXED, 64'h11, 6'd5);
    send_item(bpk_pkg::OP_RAW, 64'h0000_0000_FFFF_FFFF, 6'd33);    // flush then raw word
  endtask

  // Mostly well-formed records of fields closed by an align or raw word, the
  // rest malformed widths, too-wide values and stray raw words.
  task automatic test_random_streams(int unsigned n_items);
    int unsigned sent;
    int unsigned fields;
    int unsigned w;
    logic [63:0] v;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        fields = $urandom_range(1, 8);
        repeat (fields) begin
          w = $urandom_range(1, 32);
          if ($urandom_range(0, 2) == 0)
            send_item(bpk_pkg::OP_VBR, rand_magnitude(), (w < 2) ? 6'd2 : w[5:0]);
          else
            send_item(bpk_pkg::OP_FIXED, rand64() & width_mask(w), w[5:0]);
          sent++;
        end
        case ($urandom_range(0, 3))
          0: begin
            send_item(bpk_pkg::OP_ALIGN, rand64(), 6'($urandom_range(0, 63)));
            sent++;
          end
          1: begin
            send_item(bpk_pkg::OP_RAW, rand64(), 6'($urandom_range(0, 63)));
            sent++;
          end
          default: ;
        endcase
      end else begin
        case ($urandom_range(0, 4))
          0: begin
            w = $urandom_range(0, 31);
            v = rand64() | (64'd1 << $urandom_range(w, 63));
            send_item(bpk_pkg::OP_FIXED, v, w[5:0]);
          end
          1: begin
            v = $urandom_range(0, 1) ? rand64() : (rand64() & width_mask(32));
            send_item(bpk_pkg::OP_FIXED, v, 6'($urandom_range(33, 63)));
          end
          2: begin
            w = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(33, 63);
            send_item(bpk_pkg::OP_VBR, rand_magnitude(), w[5:0]);
          end
          3: send_item(bpk_pkg::OP_RAW, rand64(), 6'($urandom_range(0, 63)));
          default: send_item(bpk_pkg::OP_FIXED, 64'd0, 6'd0);
        endcase
        sent++;
      end
    end
  endtask

  // Pause the sender until the block has delivered everything, then go on.
  task automatic test_drain_pause();
    test_random_streams(15);
    drain_words();
    test_random_streams(15);
  endtask

  // Run the tail with both sides at full rate.
  task automatic test_full_rate();
    idle_on = 1'b0;
    test_random_streams(40);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_fixed_edges();
    test_vbr_edges();
    test_align_and_raw();
    test_random_streams(170);
    test_drain_pause();
    test_full_rate();
    drain_words();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
